// ===== rtl/core/stp_pkg.sv =====
// shared types, constants and crc helper for the smbus temperature reader
`timescale 1ns / 1ps

package stp_pkg;

    // signed temperature in tenths of a degree celsius
    typedef logic signed [14:0] t_temp;

    localparam logic [7:0]  RegAmbient = 8'h06;
    localparam logic [7:0]  RegObject  = 8'h07;
    localparam logic [7:0]  CrcPoly    = 8'h07;
    localparam logic [6:0]  AddrReset  = 7'd25;

    // kelvin offset in hundredths, raw word is in units of 0.02 K
    localparam logic [17:0] KelvinOfs  = 18'd27315;
    // floor(x / 10) == (x * 52429) >> 19 for every x below 2^18
    localparam logic [15:0] Div10Mul   = 16'd52429;
    localparam int          Div10Shift = 19;
    localparam logic [13:0] TempMaxMag = 14'd9999;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/stp_crc8.sv =====
// pec check: crc-8 over the five bytes of a read-word transaction
`timescale 1ns / 1ps

module stp_crc8 (
    input  logic [6:0] i_address,
    input  logic       i_channel,
    input  logic [7:0] i_data_low,
    input  logic [7:0] i_data_high,
    input  logic [7:0] i_pec_byte,
    output logic       o_pec_ok
);
    import stp_pkg::*;

    logic [7:0] wr_byte;
    logic [7:0] cmd_byte;
    logic [7:0] crc_wr;
    logic [7:0] crc_cmd;
    logic [7:0] crc_rd;
    logic [7:0] crc_lo;
    logic [7:0] crc_hi;

    assign wr_byte  = {i_address, 1'b0};
    assign cmd_byte = i_channel ? RegAmbient : RegObject;

    assign crc_wr   = crc8_byte(8'h00, wr_byte);
    assign crc_cmd  = crc8_byte(crc_wr, cmd_byte);
    assign crc_rd   = crc8_byte(crc_cmd, {i_address, 1'b1});
    assign crc_lo   = crc8_byte(crc_rd, i_data_low);
    assign crc_hi   = crc8_byte(crc_lo, i_data_high);

    assign o_pec_ok = (crc_hi == i_pec_byte);

endmodule

// ===== rtl/core/stp_convert.sv =====
// raw sensor word to clamped tenths of a degree celsius
`timescale 1ns / 1ps

module stp_convert (
    input  logic [15:0]          i_raw_word,
    output stp_pkg::t_temp       o_temperature
);
    import stp_pkg::*;

    logic signed [17:0] diff;
    logic               neg;
    logic [16:0]        mag;
    logic [32:0]        prod;
    logic [13:0]        quot;
    logic [13:0]        quot_sat;
    logic [14:0]        mag_ext;

    // raw*2 - 27315, in hundredths of a degree
    assign diff = $signed({1'b0, i_raw_word, 1'b0}) - $signed(KelvinOfs);
    assign neg  = diff[17];
    assign mag  = neg ? 17'(-diff) : diff[16:0];

    // divide magnitude by ten, truncating toward zero
    assign prod = {16'b0, mag} * {17'b0, Div10Mul};
    assign quot = prod[Div10Shift +: 14];

    // clamp symmetric on the magnitude
    assign quot_sat = (quot > TempMaxMag) ? TempMaxMag : quot;
    assign mag_ext  = {1'b0, quot_sat};

    assign o_temperature = neg ? t_temp'(-mag_ext) : t_temp'(mag_ext);

endmodule

// ===== rtl/core/smbus_temp_read_pec_check.sv =====
// smbus read-word temperature checker with pec verification (top level)
`timescale 1ns / 1ps
// path from input transaction to result valid: input reg, then result reg
// throughput: one transaction per cycle while the output is not stalled, set by the single crc/convert pass
// reset (synchronous, active low): both pipeline stages empty, channel toggle
// cleared, stored temperatures zero, device address back to 25

module smbus_temp_read_pec_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // apb-style configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,

    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_low,
    input  logic [7:0]           i_data_high,
    input  logic [7:0]           i_pec_byte,

    // result transactions
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_channel,
    output stp_pkg::t_temp       o_temperature,
    output logic                 o_pec_ok,
    output logic [15:0]          o_raw_word
);
    import stp_pkg::*;

    // register index (paddr bit 2, byte lanes ignored)
    localparam logic IdxDeviceAddress = 1'b0;

    // configuration
    logic [6:0]  r_address;
    logic        cfg_write;

    // input stage
    logic        r_s1_valid;
    logic [7:0]  r_s1_low;
    logic [7:0]  r_s1_high;
    logic [7:0]  r_s1_pec;

    // per-channel state
    logic        r_toggle;
    t_temp       r_temp_object;
    t_temp       r_temp_ambient;

    // result stage
    logic        r_out_valid;
    logic        r_out_channel;
    t_temp       r_out_temp;
    logic        r_out_ok;
    logic [15:0] r_out_raw;

    // datapath between the stages
    logic        out_free;
    logic        s1_adv;
    logic        in_take;
    logic        s1_channel;
    logic [15:0] s1_raw;
    logic        s1_ok;
    t_temp       s1_conv;
    t_temp       s1_stored;
    t_temp       s1_result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == IdxDeviceAddress) ? {25'b0, r_address} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= AddrReset;
        end else if (cfg_write && (paddr[2] == IdxDeviceAddress)) begin
            r_address <= pwdata[6:0];
        end
    end

    // ---------------- handshake ----------------
    // result register frees when empty or being taken; the input register
    // moves into it whenever it is free, so a new transaction enters each cycle while it stays free
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_low  <= i_data_low;
            r_s1_high <= i_data_high;
            r_s1_pec  <= i_pec_byte;
        end
    end

    // ---------------- single-pass work ----------------
    // channel flips before each transaction: first after reset is ambient
    assign s1_channel = ~r_toggle;
    assign s1_raw     = {r_s1_high, r_s1_low};

    stp_crc8 u_crc8 (
        .i_address   (r_address),
        .i_channel   (s1_channel),
        .i_data_low  (r_s1_low),
        .i_data_high (r_s1_high),
        .i_pec_byte  (r_s1_pec),
        .o_pec_ok    (s1_ok)
    );

    stp_convert u_convert (
        .i_raw_word    (s1_raw),
        .o_temperature (s1_conv)
    );

    // on a pec mismatch the channel keeps and reports its stored value
    assign s1_stored = s1_channel ? r_temp_ambient : r_temp_object;
    assign s1_result = s1_ok ? s1_conv : s1_stored;

    // ---------------- channel state ----------------
    // updated only as a transaction leaves the input register, so order holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle       <= 1'b0;
            r_temp_object  <= '0;
            r_temp_ambient <= '0;
        end else if (s1_adv) begin
            r_toggle <= s1_channel;
            if (s1_ok) begin
                if (s1_channel) begin
                    r_temp_ambient <= s1_conv;
                end else begin
                    r_temp_object <= s1_conv;
                end
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_channel <= s1_channel;
            r_out_temp    <= s1_result;
            r_out_ok      <= s1_ok;
            r_out_raw     <= s1_raw;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel     = r_out_channel;
    assign o_temperature = r_out_temp;
    assign o_pec_ok      = r_out_ok;
    assign o_raw_word    = r_out_raw;

    // ---------------- assertions ----------------
    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    // a pending result always matches the stored value of its channel
    a_out_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_temp == (r_out_channel ? r_temp_ambient : r_temp_object))
        else $error("result temperature differs from stored channel value");

    // consecutive results alternate between channels
    a_channel_alternates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready) |=> !r_out_valid || (r_out_channel != $past(r_out_channel)))
        else $error("channel did not alternate");

    // stored values stay within the clamp range
    a_store_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_temp_object <= 15'sd9999) && (r_temp_object >= -15'sd9999) &&
        (r_temp_ambient <= 15'sd9999) && (r_temp_ambient >= -15'sd9999))
        else $error("stored temperature out of range");

endmodule
